[hdl/humidity_temp_frame_decoder_core_assert.svh]
// Assertion macros shared by the sensor frame decoder modules.
// Depends on nothing; included by the modules that carry checks.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_CORE_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HTFD_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HTFD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/htfd_pkg.sv]
// Shared types, constants and functions of the sensor frame decoder.
// Depends on nothing; imported by every module of the decoder.
`timescale 1ns / 1ps

package htfd_pkg;

    localparam int unsigned CFG_INDEX_W = 4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_CRC_POLYNOMIAL = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CRC_INITIAL    = 4'd1;

    localparam logic [7:0] CRC_POLY_RESET = 8'h31;
    localparam logic [7:0] CRC_INIT_RESET = 8'hFF;

    // Conversion constants: full scale is 65535 counts.
    localparam logic [10:0]        TEMP_SCALE   = 11'd1750;
    localparam logic [9:0]         HUMI_SCALE   = 10'd1000;
    localparam logic signed [11:0] TEMP_OFFSET  = 12'sd450;
    localparam logic signed [11:0] TEMP_X10_MIN = -12'sd450;
    localparam logic signed [11:0] TEMP_X10_MAX = 12'sd1300;
    localparam logic [9:0]         HUMI_X10_MAX = 10'd1000;

    // Raw words of a completed frame and their check flags.
    typedef struct packed {
        logic [15:0] temp_raw;
        logic [15:0] humi_raw;
        logic        temp_bad;
        logic        humi_bad;
    } htfd_words_t;

    // Converted measurement.
    typedef struct packed {
        logic signed [11:0] temperature_x10;
        logic [9:0]         humidity_x10;
        logic               temp_crc_bad;
        logic               humi_crc_bad;
    } htfd_result_t;

    // One byte of CRC-8, MSB first.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                               input logic [7:0] data,
                                               input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // floor(x / 65535) for x below 2^27: x = q*65535 + r gives
    // (x + (x >> 16) + 1) >> 16 == q while q stays under 65536.
    function automatic logic [10:0] div_full_scale(input logic [26:0] x);
        logic [27:0] s;
        s = {1'b0, x} + {17'd0, x[26:16]} + 28'd1;
        return s[26:16];
    endfunction

endpackage

[hdl/htfd_frame_track.sv]
// Frame byte tracker: byte position, CRC-8 per word, word capture.
// Depends on htfd_pkg; feeds the raw words of each frame to htfd_convert.
`timescale 1ns / 1ps
`include "humidity_temp_frame_decoder_core_assert.svh"

module htfd_frame_track (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic [7:0]           in_byte,
    output logic                 in_ready,
    input  logic [7:0]           crc_poly,
    input  logic [7:0]           crc_init,
    output logic                 words_valid,
    output htfd_pkg::htfd_words_t words,
    input  logic                 words_ready
);
    import htfd_pkg::*;

    typedef enum logic [2:0] {
        POS_T_MSB = 3'd0,
        POS_T_LSB = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_MSB = 3'd3,
        POS_H_LSB = 3'd4,
        POS_H_CRC = 3'd5
    } pos_t;

    pos_t        pos_reg;
    logic [7:0]  crc_reg;
    logic [7:0]  high_reg;
    logic [7:0]  low_reg;
    logic [15:0] temp_raw_reg;
    logic        first_bad_reg;
    logic        words_valid_reg;
    htfd_words_t words_reg;
    logic        accept;

    // Bytes are taken only while no words are held or the held words move on.
    assign in_ready    = !words_valid_reg || words_ready;
    assign accept      = in_valid && in_ready;
    assign words_valid = words_valid_reg;
    assign words       = words_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= POS_T_MSB;
            words_valid_reg <= 1'b0;
        end else begin
            if (words_ready) begin
                words_valid_reg <= 1'b0;
            end
            if (accept) begin
                unique case (pos_reg)
                    POS_T_MSB, POS_H_MSB: begin
                        high_reg <= in_byte;
                        crc_reg  <= crc8_update(crc_init, in_byte, crc_poly);
                        pos_reg  <= (pos_reg == POS_T_MSB) ? POS_T_LSB : POS_H_LSB;
                    end
                    POS_T_LSB, POS_H_LSB: begin
                        low_reg <= in_byte;
                        crc_reg <= crc8_update(crc_reg, in_byte, crc_poly);
                        pos_reg <= (pos_reg == POS_T_LSB) ? POS_T_CRC : POS_H_CRC;
                    end
                    POS_T_CRC: begin
                        temp_raw_reg  <= {high_reg, low_reg};
                        first_bad_reg <= (crc_reg != in_byte);
                        pos_reg       <= POS_H_MSB;
                    end
                    POS_H_CRC: begin
                        words_reg.temp_raw <= temp_raw_reg;
                        words_reg.humi_raw <= {high_reg, low_reg};
                        words_reg.temp_bad <= first_bad_reg;
                        words_reg.humi_bad <= (crc_reg != in_byte);
                        words_valid_reg    <= 1'b1;
                        pos_reg            <= POS_T_MSB;
                    end
                    default: begin
                        // Unused codes restart the frame.
                        pos_reg <= POS_T_MSB;
                    end
                endcase
            end
        end
    end

    `HTFD_ASSERT_NEXT(a_frame_end, aclk, aresetn, accept && (pos_reg == POS_H_CRC), words_valid_reg && (pos_reg == POS_T_MSB), "last byte did not release the words or restart the frame")
    `HTFD_ASSERT_NEXT(a_temp_capture, aclk, aresetn, accept && (pos_reg == POS_T_CRC), temp_raw_reg == $past({high_reg, low_reg}), "temperature word not captured at its check byte")

endmodule

[hdl/htfd_convert.sv]
// Scaling pipeline: constant multiply, then divide by full scale and offset.
// Depends on htfd_pkg; takes words from htfd_frame_track.
`timescale 1ns / 1ps

module htfd_convert (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   words_valid,
    input  htfd_pkg::htfd_words_t  words,
    output logic                   words_ready,
    output logic                   res_valid,
    output htfd_pkg::htfd_result_t res,
    input  logic                   res_ready
);
    import htfd_pkg::*;

    logic         prod_valid_reg;
    logic [26:0]  temp_prod_reg;
    logic [25:0]  humi_prod_reg;
    logic         temp_bad_reg;
    logic         humi_bad_reg;
    logic [26:0]  temp_prod_next;
    logic [25:0]  humi_prod_next;
    logic         res_valid_reg;
    htfd_result_t res_reg;
    htfd_result_t res_next;
    logic         prod_ready;
    logic         out_ready;
    logic [10:0]  temp_q;
    logic [10:0]  humi_q;

    assign out_ready   = !res_valid_reg || res_ready;
    assign prod_ready  = !prod_valid_reg || out_ready;
    assign words_ready = prod_ready;
    assign res_valid   = res_valid_reg;
    assign res         = res_reg;

    assign temp_prod_next = 27'(TEMP_SCALE) * 27'(words.temp_raw);
    assign humi_prod_next = 26'(HUMI_SCALE) * 26'(words.humi_raw);

    always_comb begin
        temp_q                   = div_full_scale(temp_prod_reg);
        humi_q                   = div_full_scale({1'b0, humi_prod_reg});
        res_next.temperature_x10 = $signed({1'b0, temp_q}) - TEMP_OFFSET;
        res_next.humidity_x10    = humi_q[9:0];
        res_next.temp_crc_bad    = temp_bad_reg;
        res_next.humi_crc_bad    = humi_bad_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            if (prod_ready) begin
                prod_valid_reg <= words_valid;
            end
            if (out_ready) begin
                res_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_ready && words_valid) begin
            temp_prod_reg <= temp_prod_next;
            humi_prod_reg <= humi_prod_next;
            temp_bad_reg  <= words.temp_bad;
            humi_bad_reg  <= words.humi_bad;
        end
        if (out_ready && prod_valid_reg) begin
            res_reg <= res_next;
        end
    end

endmodule

[hdl/humidity_temp_frame_decoder_core.sv]
// Top level of the sensor frame decoder: ports, configuration registers, packing.
// Depends on htfd_pkg, htfd_frame_track and htfd_convert.
`timescale 1ns / 1ps
`include "humidity_temp_frame_decoder_core_assert.svh"

// Sensor frame decoder. Feed the six bytes of each measurement frame on the
// s_ stream, one byte per transaction: temperature MSB, LSB, CRC, then
// humidity MSB, LSB, CRC. Each two-byte word is checked with an MSB-first
// CRC-8 whose polynomial (register 0, reset 0x31) and start value
// (register 1, reset 0xFF) come from the configuration channel; the start
// value is sampled at the first byte of each word, so write the registers
// between frames. The sixth byte yields one m_ transaction with temperature
// in tenths of a degree C, floor(1750*raw/65535)-450, and humidity in
// tenths of a percent, floor(1000*raw/65535). The values are always given;
// treat them as valid only when both CRC flags in m_tuser are clear.
// Rate: one byte per clock while s_tready is high. m_tvalid rises after the
// edge that takes the sixth byte: the word register loads at that edge, then
// the multiply stage and the divide stage follow; each stage has its own
// valid bit, so s_tready drops only when all of them are full and m_tready
// is low.
module humidity_temp_frame_decoder_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input bytes
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] byte_in
    // Results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [23:0]                        m_tdata,   // [11:0] temperature_x10,
                                                          // [21:12] humidity_x10,
                                                          // [23:22] zero
    output logic [1:0]                         m_tuser,   // [0] temp_crc_bad,
                                                          // [1] humi_crc_bad
    // Configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [htfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [7:0]                         cfg_wdata
);
    import htfd_pkg::*;

    logic [7:0]   crc_poly_q_reg;
    logic [7:0]   crc_init_reg;
    logic         words_valid;
    htfd_words_t  words;
    logic         words_ready;
    htfd_result_t res;

    // Configuration writes are always accepted.
    assign cfg_ready = 1'b1;

    // Hold the CRC registers; drop writes to unknown indexes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_poly_q_reg <= CRC_POLY_RESET;
            crc_init_reg   <= CRC_INIT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CRC_POLYNOMIAL: begin
                    crc_poly_q_reg <= cfg_wdata;
                end
                REG_CRC_INITIAL: begin
                    crc_init_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // Track frame position and checksums; release both words at frame end.
    htfd_frame_track u_track (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_byte     (s_tdata),
        .in_ready    (s_tready),
        .crc_poly    (crc_poly_q_reg),
        .crc_init    (crc_init_reg),
        .words_valid (words_valid),
        .words       (words),
        .words_ready (words_ready)
    );

    // Scale the raw words into tenths.
    htfd_convert u_convert (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .words_valid (words_valid),
        .words       (words),
        .words_ready (words_ready),
        .res_valid   (m_tvalid),
        .res         (res),
        .res_ready   (m_tready)
    );

    // Pack the result transaction.
    assign m_tdata = {2'b00, res.humidity_x10, res.temperature_x10};
    assign m_tuser = {res.humi_crc_bad, res.temp_crc_bad};

    `HTFD_ASSERT_IMPLY(a_stall_needs_result, aclk, aresetn, !s_tready, m_tvalid && !m_tready, "input stalled without a blocked result")
    `HTFD_ASSERT_IMPLY(a_temp_range, aclk, aresetn, m_tvalid, ($signed(m_tdata[11:0]) >= TEMP_X10_MIN) && ($signed(m_tdata[11:0]) <= TEMP_X10_MAX), "temperature out of range")
    `HTFD_ASSERT_IMPLY(a_humi_range, aclk, aresetn, m_tvalid, m_tdata[21:12] <= HUMI_X10_MAX, "humidity out of range")

endmodule
